>>> hw/rtl/srpg_pkg.sv
package srpg_pkg;

    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int POS_WIDTH       = 32;
    localparam int DIR_WIDTH       = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_TARGET_PERIOD    = 3'd0,
        REG_START_PERIOD     = 3'd1,
        REG_RAMP_DOWN_STEPS  = 3'd2,
        REG_RAMP_UP_AMOUNT   = 3'd3,
        REG_RAMP_DOWN_AMOUNT = 3'd4,
        REG_MICROSTEP_SHIFT  = 3'd5
    } cfg_index_t;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [DIR_WIDTH-1:0] DIR_NONE    = 2'b00;
    localparam logic [DIR_WIDTH-1:0] DIR_UP      = 2'b01;
    localparam logic [DIR_WIDTH-1:0] DIR_NEG_TWO = 2'b10;
    localparam logic [DIR_WIDTH-1:0] DIR_NEG_ONE = 2'b11;

    localparam logic [15:0] TARGET_PERIOD_RESET    = 16'd1000;
    localparam logic [15:0] START_PERIOD_RESET     = 16'd2000;
    localparam logic [15:0] RAMP_DOWN_STEPS_RESET  = 16'd0;
    localparam logic [7:0]  RAMP_UP_AMOUNT_RESET   = 8'd1;
    localparam logic [7:0]  RAMP_DOWN_AMOUNT_RESET = 8'd1;
    localparam logic [3:0]  MICROSTEP_SHIFT_RESET  = 4'd0;

    typedef struct packed {
        logic [15:0] target_period;
        logic [15:0] start_period;
        logic [15:0] ramp_down_steps;
        logic [7:0]  ramp_up_amount;
        logic [7:0]  ramp_down_amount;
        logic [3:0]  microstep_shift;
    } cfg_t;

endpackage

>>> hw/rtl/srpg_cfg_regs.sv
module srpg_cfg_regs (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [srpg_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [srpg_pkg::CFG_DATA_WIDTH-1:0]    cfg_wr_data,
    output srpg_pkg::cfg_t                         cfg
);
    import srpg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_period    <= TARGET_PERIOD_RESET;
            cfg_reg.start_period     <= START_PERIOD_RESET;
            cfg_reg.ramp_down_steps  <= RAMP_DOWN_STEPS_RESET;
            cfg_reg.ramp_up_amount   <= RAMP_UP_AMOUNT_RESET;
            cfg_reg.ramp_down_amount <= RAMP_DOWN_AMOUNT_RESET;
            cfg_reg.microstep_shift  <= MICROSTEP_SHIFT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET_PERIOD:    cfg_reg.target_period    <= cfg_wr_data;
                REG_START_PERIOD:     cfg_reg.start_period     <= cfg_wr_data;
                REG_RAMP_DOWN_STEPS:  cfg_reg.ramp_down_steps  <= cfg_wr_data;
                REG_RAMP_UP_AMOUNT:   cfg_reg.ramp_up_amount   <= cfg_wr_data[7:0];
                REG_RAMP_DOWN_AMOUNT: cfg_reg.ramp_down_amount <= cfg_wr_data[7:0];
                REG_MICROSTEP_SHIFT:  cfg_reg.microstep_shift  <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/srpg_in_stage.sv
module srpg_in_stage #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [COUNT_WIDTH-1:0]              s_move_steps,
    input  logic [srpg_pkg::DIR_WIDTH-1:0]      s_direction,
    input  logic                                s_mid_switch,
    input  logic                                s_stop_request,
    input  logic                                advance,
    output logic                                item_valid,
    output logic                                item_kind,
    output logic [COUNT_WIDTH-1:0]              item_steps,
    output logic [srpg_pkg::DIR_WIDTH-1:0]      item_dir,
    output logic                                item_mid,
    output logic                                item_stop
);
    import srpg_pkg::*;

    logic                   valid_reg;
    logic                   kind_reg;
    logic [COUNT_WIDTH-1:0] steps_reg;
    logic [DIR_WIDTH-1:0]   dir_reg;
    logic                   mid_reg;
    logic                   stop_reg;

    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg  <= s_kind;
            steps_reg <= s_move_steps;
            dir_reg   <= s_direction;
            mid_reg   <= s_mid_switch;
            stop_reg  <= s_stop_request;
        end
    end

    assign item_valid = valid_reg;
    assign item_kind  = kind_reg;
    assign item_steps = steps_reg;
    assign item_dir   = dir_reg;
    assign item_mid   = mid_reg;
    assign item_stop  = stop_reg;

endmodule

>>> hw/rtl/srpg_core.sv
module srpg_core #(
    parameter int COUNT_WIDTH  = 24,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  srpg_pkg::cfg_t                      cfg,
    input  logic                                step_en,
    input  logic                                item_kind,
    input  logic [COUNT_WIDTH-1:0]              item_steps,
    input  logic [srpg_pkg::DIR_WIDTH-1:0]      item_dir,
    input  logic                                item_mid,
    input  logic                                item_stop,
    output logic [PERIOD_WIDTH-1:0]             period_next,
    output logic [COUNT_WIDTH-1:0]              count_next,
    output logic [srpg_pkg::POS_WIDTH-1:0]      position_next,
    output logic                                moving_next,
    output logic                                homed_next
);
    import srpg_pkg::*;

    localparam int PX = ((PERIOD_WIDTH > 16) ? PERIOD_WIDTH : 16) + 1;
    localparam int CX = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [PERIOD_WIDTH-1:0] period_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [POS_WIDTH-1:0]    position_reg;
    logic                    moving_reg;
    logic                    homed_reg;
    logic                    last_mid_reg;
    logic                    last_mid_next;

    logic [PX-1:0]           target_x;
    logic [PX-1:0]           start_x;
    logic [PX-1:0]           cur_x;
    logic [PX-1:0]           sum_x;
    logic [PX-1:0]           gap_x;
    logic [PX-1:0]           sat_x;
    logic [COUNT_WIDTH-1:0]  dec_count;
    logic                    end_move;
    logic [POS_WIDTH-1:0]    weight;
    logic [POS_WIDTH-1:0]    mag;
    logic [POS_WIDTH-1:0]    moved_pos;

    always_comb begin
        target_x  = PX'(cfg.target_period);
        start_x   = PX'(cfg.start_period);
        cur_x     = PX'(period_reg);
        sat_x     = {{(PX-PERIOD_WIDTH){1'b0}}, {PERIOD_WIDTH{1'b1}}};
        sum_x     = cur_x + PX'(cfg.ramp_down_amount);
        gap_x     = cur_x - target_x;
        dec_count = count_reg - COUNT_WIDTH'(1);
        end_move  = (dec_count == '0) || item_stop;
        weight    = POS_WIDTH'(1) << cfg.microstep_shift;
        case (item_dir)
            DIR_NONE:    mag = '0;
            DIR_NEG_TWO: mag = weight << 1;
            default:     mag = weight;
        endcase
        moved_pos = item_dir[1] ? (position_reg - mag) : (position_reg + mag);

        period_next   = period_reg;
        count_next    = count_reg;
        position_next = position_reg;
        moving_next   = moving_reg;
        homed_next    = homed_reg;
        last_mid_next = last_mid_reg;

        if (item_kind == KIND_START) begin
            count_next  = COUNT_WIDTH'(item_steps >> cfg.microstep_shift);
            period_next = (target_x > start_x) ? PERIOD_WIDTH'(target_x)
                                               : PERIOD_WIDTH'(start_x);
            moving_next = (count_next != '0);
        end else if (moving_reg) begin
            count_next  = end_move ? '0 : dec_count;
            moving_next = !end_move;
            if (CX'(count_next) < CX'(cfg.ramp_down_steps)) begin
                period_next = (sum_x > sat_x) ? {PERIOD_WIDTH{1'b1}} : PERIOD_WIDTH'(sum_x);
            end else if (cur_x > target_x) begin
                period_next = (gap_x > PX'(cfg.ramp_up_amount))
                            ? PERIOD_WIDTH'(cur_x - PX'(cfg.ramp_up_amount))
                            : PERIOD_WIDTH'(target_x);
            end
            position_next = moved_pos;
            if (last_mid_reg && !item_mid && item_dir[1]) begin
                position_next = POS_WIDTH'(1);
                homed_next    = 1'b1;
            end
            last_mid_next = item_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_WIDTH'(START_PERIOD_RESET);
            count_reg    <= '0;
            position_reg <= '0;
            moving_reg   <= 1'b0;
            homed_reg    <= 1'b0;
            last_mid_reg <= 1'b0;
        end else if (step_en) begin
            period_reg   <= period_next;
            count_reg    <= count_next;
            position_reg <= position_next;
            moving_reg   <= moving_next;
            homed_reg    <= homed_next;
            last_mid_reg <= last_mid_next;
        end
    end

    a_moving_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg == (count_reg != '0))
        else $error("moving flag disagrees with remaining count");

    a_homed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(homed_reg))
        else $error("homed flag cleared outside reset");

    a_idle_tick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item_kind == KIND_TICK && !moving_reg)
        |=> ($stable(period_reg) && $stable(position_reg) && $stable(last_mid_reg)))
        else $error("tick while idle changed state");

endmodule

>>> hw/rtl/stepper_ramp_pulse_generator_unit.sv
// A result passes through the input register and then the output register, where it waits for m_ready.
// Throughput: one item per cycle while m_ready is high; the single-pass state update sets that figure.
// While a result waits, the input register holds one more item; s_ready then follows m_ready.
// Reset (aresetn low, synchronous) loads the default configuration, sets the period to the
// default start period and clears count, position, homed, moving and both valid flags.
module stepper_ramp_pulse_generator_unit #(
    parameter int COUNT_WIDTH  = 24,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [srpg_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [srpg_pkg::CFG_DATA_WIDTH-1:0]    cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_kind,
    input  logic [COUNT_WIDTH-1:0]                 s_move_steps,
    input  logic signed [srpg_pkg::DIR_WIDTH-1:0]  s_direction,
    input  logic                                   s_mid_switch,
    input  logic                                   s_stop_request,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [PERIOD_WIDTH-1:0]                m_pulse_period,
    output logic [PERIOD_WIDTH-2:0]                m_pulse_compare,
    output logic                                   m_running,
    output logic [COUNT_WIDTH-1:0]                 m_steps_left,
    output logic signed [srpg_pkg::POS_WIDTH-1:0]  m_position,
    output logic                                   m_homed
);
    import srpg_pkg::*;

    cfg_t                    cfg;
    logic                    advance;
    logic                    step_en;
    logic                    item_valid;
    logic                    item_kind;
    logic [COUNT_WIDTH-1:0]  item_steps;
    logic [DIR_WIDTH-1:0]    item_dir;
    logic                    item_mid;
    logic                    item_stop;
    logic [PERIOD_WIDTH-1:0] period_next;
    logic [COUNT_WIDTH-1:0]  count_next;
    logic [POS_WIDTH-1:0]    position_next;
    logic                    moving_next;
    logic                    homed_next;

    logic                    out_valid_reg;
    logic [PERIOD_WIDTH-1:0] out_period_reg;
    logic [COUNT_WIDTH-1:0]  out_count_reg;
    logic [POS_WIDTH-1:0]    out_position_reg;
    logic                    out_moving_reg;
    logic                    out_homed_reg;

    srpg_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    srpg_in_stage #(.COUNT_WIDTH(COUNT_WIDTH)) u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_move_steps   (s_move_steps),
        .s_direction    (s_direction),
        .s_mid_switch   (s_mid_switch),
        .s_stop_request (s_stop_request),
        .advance        (advance),
        .item_valid     (item_valid),
        .item_kind      (item_kind),
        .item_steps     (item_steps),
        .item_dir       (item_dir),
        .item_mid       (item_mid),
        .item_stop      (item_stop)
    );

    srpg_core #(.COUNT_WIDTH(COUNT_WIDTH), .PERIOD_WIDTH(PERIOD_WIDTH)) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .step_en       (step_en),
        .item_kind     (item_kind),
        .item_steps    (item_steps),
        .item_dir      (item_dir),
        .item_mid      (item_mid),
        .item_stop     (item_stop),
        .period_next   (period_next),
        .count_next    (count_next),
        .position_next (position_next),
        .moving_next   (moving_next),
        .homed_next    (homed_next)
    );

    assign advance = !out_valid_reg || m_ready;
    assign step_en = item_valid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_period_reg   <= period_next;
            out_count_reg    <= count_next;
            out_position_reg <= position_next;
            out_moving_reg   <= moving_next;
            out_homed_reg    <= homed_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pulse_period  = out_period_reg;
    assign m_pulse_compare = out_period_reg[PERIOD_WIDTH-1:1];
    assign m_running       = out_moving_reg;
    assign m_steps_left    = out_count_reg;
    assign m_position      = out_position_reg;
    assign m_homed         = out_homed_reg;

    a_running_has_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_running) |-> (m_steps_left != '0))
        else $error("running result reports no remaining steps");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_ready) |-> (item_valid && m_valid && !m_ready))
        else $error("input stalled without a full pipeline");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready)
        |=> (m_valid && $stable(m_pulse_period) && $stable(m_steps_left)
             && $stable(m_position)))
        else $error("waiting result changed before its transfer");

endmodule
